>>> sv/qte_pkg.sv
`default_nettype none
package qte_pkg;

  // widths
  localparam int RW = 35;        // rotation-matrix entries, 1.0 = 2^30
  localparam int CW = 38;        // cordic x/y datapath
  localparam int ZW = 34;        // cordic angle, 29 fraction bits
  localparam int NW = 61;        // square-root radicand
  localparam int SW = 62;        // square-root partial root
  localparam int SQ_STEPS = 31;  // one root bit per cell

  localparam logic signed [RW-1:0] ONE_R = RW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_PI_A = ZW'(64'sd843314857);
  localparam logic signed [ZW-1:0] PI_Q = ZW'(64'sd25736);
  localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(64'sd12868);

  typedef struct packed {
    logic signed [RW-1:0] r20;
    logic signed [RW-1:0] r21;
    logic signed [RW-1:0] r22;
    logic signed [RW-1:0] r10;
    logic signed [RW-1:0] r00;
  } mat_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [SW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  // atan(2^-i) with 29 fraction bits
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        5'd0: v = ZW'(64'sd421657428);
        5'd1: v = ZW'(64'sd248918915);
        5'd2: v = ZW'(64'sd131521918);
        5'd3: v = ZW'(64'sd66762579);
        5'd4: v = ZW'(64'sd33510843);
        5'd5: v = ZW'(64'sd16771758);
        5'd6: v = ZW'(64'sd8387925);
        5'd7: v = ZW'(64'sd4194219);
        5'd8: v = ZW'(64'sd2097141);
        5'd9: v = ZW'(64'sd1048575);
        5'd10: v = ZW'(64'sd524288);
        5'd11: v = ZW'(64'sd262144);
        5'd12: v = ZW'(64'sd131072);
        5'd13: v = ZW'(64'sd65536);
        5'd14: v = ZW'(64'sd32768);
        5'd15: v = ZW'(64'sd16384);
        5'd16: v = ZW'(64'sd8192);
        5'd17: v = ZW'(64'sd4096);
        5'd18: v = ZW'(64'sd2048);
        5'd19: v = ZW'(64'sd1024);
        5'd20: v = ZW'(64'sd512);
        5'd21: v = ZW'(64'sd256);
        5'd22: v = ZW'(64'sd128);
        5'd23: v = ZW'(64'sd64);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/qte_matrix.sv
`default_nettype none
module qte_matrix (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic signed [15:0]  w,
  input  wire logic signed [15:0]  x,
  input  wire logic signed [15:0]  y,
  input  wire logic signed [15:0]  z,
  output qte_pkg::mat_t            mat_r
);

  logic signed [31:0] xz_r, wy_r, yz_r, wx_r, xx_r, yy_r, xy_r, wz_r, zz_r;
  qte_pkg::mat_t mat_nxt;

  // products
  always_ff @(posedge clk) begin
    if (adv) begin
      xz_r <= x * z;
      wy_r <= w * y;
      yz_r <= y * z;
      wx_r <= w * x;
      xx_r <= x * x;
      yy_r <= y * y;
      xy_r <= x * y;
      wz_r <= w * z;
      zz_r <= z * z;
    end
  end

  // matrix entries
  always_comb begin
    mat_nxt.r20 = (qte_pkg::RW'(xz_r) - qte_pkg::RW'(wy_r)) <<< 1;
    mat_nxt.r21 = (qte_pkg::RW'(yz_r) + qte_pkg::RW'(wx_r)) <<< 1;
    mat_nxt.r22 = qte_pkg::ONE_R - ((qte_pkg::RW'(xx_r) + qte_pkg::RW'(yy_r)) <<< 1);
    mat_nxt.r10 = (qte_pkg::RW'(xy_r) + qte_pkg::RW'(wz_r)) <<< 1;
    mat_nxt.r00 = qte_pkg::ONE_R - ((qte_pkg::RW'(yy_r) + qte_pkg::RW'(zz_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_r <= mat_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/qte_sqrt_cell.sv
`default_nettype none
module qte_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire qte_pkg::sq_t sq_in,
  output qte_pkg::sq_t     sq_r
);

  localparam logic [qte_pkg::SW-1:0] BITV = qte_pkg::SW'(1) << (60 - 2 * STAGE);

  logic [qte_pkg::SW-1:0] trial;
  qte_pkg::sq_t sq_nxt;

  // one root bit: compare and subtract
  always_comb begin
    trial = sq_in.res + BITV;
    if ({1'b0, sq_in.rem} >= trial) begin
      sq_nxt.rem = sq_in.rem - trial[qte_pkg::NW-1:0];
      sq_nxt.res = (sq_in.res >> 1) + BITV;
    end else begin
      sq_nxt.rem = sq_in.rem;
      sq_nxt.res = sq_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= sq_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/qte_cordic_cell.sv
`default_nettype none
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire qte_pkg::cordic_t c_in,
  output qte_pkg::cordic_t     c_r
);

  localparam logic signed [qte_pkg::ZW-1:0] ATAN = qte_pkg::atan_val(5'(STAGE));

  logic signed [qte_pkg::CW-1:0] dx, dy;
  qte_pkg::cordic_t c_nxt;

  // one vectoring rotation toward y = 0
  always_comb begin
    dx = c_in.y >>> STAGE;
    dy = c_in.x >>> STAGE;
    c_nxt.zero = c_in.zero;
    if (!c_in.y[qte_pkg::CW-1] && (c_in.y != '0)) begin
      c_nxt.x = c_in.x + dx;
      c_nxt.y = c_in.y - dy;
      c_nxt.z = c_in.z + ATAN;
    end else begin
      c_nxt.x = c_in.x - dx;
      c_nxt.y = c_in.y + dy;
      c_nxt.z = c_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/quaternion_to_euler_xyz_unit.sv
`default_nettype none
// Unit quaternion (Q1.15) to roll/pitch/yaw (radians, xyz order; roll and yaw
// Q3.13, pitch Q2.13). Fully pipelined: one request per clock unless the result
// side stalls, made of the matrix product and matrix entry registers, the pitch
// radicand register, 31 square-root cells, one quadrant fold, CORDIC_STEPS
// rotation cells (three CORDIC rows run side by side) and the output register.
// A stall on the result side holds the whole pipeline. gimbal_locked marks
// |r20| >= 1, where yaw reads 0 and pitch is +-pi/2.
module quaternion_to_euler_xyz_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_roll_angle,
  output logic signed [14:0]      out_pitch_angle,
  output logic signed [15:0]      out_yaw_angle,
  output logic                    out_gimbal_locked
);

  localparam int SQ = qte_pkg::SQ_STEPS;
  localparam int LAT = CORDIC_STEPS + 36;
  localparam int CW = qte_pkg::CW;
  localparam int ZW = qte_pkg::ZW;
  localparam int RW = qte_pkg::RW;

  typedef struct packed {
    logic signed [RW-1:0] r20;
    logic signed [RW-1:0] r21;
    logic signed [RW-1:0] r22;
    logic signed [RW-1:0] r10;
    logic signed [RW-1:0] r00;
    logic                 lock;
  } side_t;

  logic adv;
  logic [LAT-1:0] vld_r;
  qte_pkg::mat_t mat_r;
  side_t side_r [0:SQ];
  qte_pkg::sq_t sq_arr [0:SQ];
  qte_pkg::cordic_t roll_c [0:CORDIC_STEPS];
  qte_pkg::cordic_t pitch_c [0:CORDIC_STEPS];
  qte_pkg::cordic_t yaw_c [0:CORDIC_STEPS];
  logic lock_r [0:CORDIC_STEPS];
  logic neg_r [0:CORDIC_STEPS];

  logic signed [RW-1:0] r20_abs;
  logic [59:0] s2;
  logic lock_nxt;
  logic signed [15:0] roll_nxt, yaw_nxt;
  logic signed [14:0] pitch_nxt;

  assign adv = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[LAT-1];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  qte_matrix u_matrix (
    .clk(clk), .adv(adv),
    .w(in_quat_w), .x(in_quat_x), .y(in_quat_y), .z(in_quat_z),
    .mat_r(mat_r)
  );

  // lock test and radicand 1 - r20^2
  always_comb begin
    lock_nxt = (mat_r.r20 >= qte_pkg::ONE_R) || (mat_r.r20 <= -qte_pkg::ONE_R);
    r20_abs = mat_r.r20[RW-1] ? -mat_r.r20 : mat_r.r20;
    s2 = r20_abs[29:0] * r20_abs[29:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{mat_r.r20, mat_r.r21, mat_r.r22, mat_r.r10, mat_r.r00, lock_nxt};
      sq_arr[0].rem <= lock_nxt ? '0 : ((qte_pkg::NW'(1) << 60) - qte_pkg::NW'(s2));
      sq_arr[0].res <= '0;
    end
  end

  // square-root cells with the side data delayed alongside
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    qte_sqrt_cell #(.STAGE(k)) u_sq (
      .clk(clk), .adv(adv), .sq_in(sq_arr[k]), .sq_r(sq_arr[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // quadrant fold into the right half plane
  function automatic qte_pkg::cordic_t fold(input logic signed [CW-1:0] y,
                                            input logic signed [CW-1:0] x);
    qte_pkg::cordic_t c;
    begin
      c.zero = (x == '0) && (y == '0);
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x[CW-1]) begin
        if (!y[CW-1]) begin
          c.x = y;
          c.y = -x;
          c.z = qte_pkg::HALF_PI_A;
        end else begin
          c.x = -y;
          c.y = x;
          c.z = -qte_pkg::HALF_PI_A;
        end
      end
      return c;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_c[0]  <= fold(CW'(side_r[SQ].r21), CW'(side_r[SQ].r22));
      yaw_c[0]   <= fold(CW'(side_r[SQ].r10), CW'(side_r[SQ].r00));
      pitch_c[0] <= fold(CW'(side_r[SQ].r20), CW'({1'b0, sq_arr[SQ].res[30:0]}));
      lock_r[0]  <= side_r[SQ].lock;
      neg_r[0]   <= side_r[SQ].r20[RW-1];
    end
  end

  // three rotation rows
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qte_cordic_cell #(.STAGE(i)) u_roll (
      .clk(clk), .adv(adv), .c_in(roll_c[i]), .c_r(roll_c[i+1])
    );
    qte_cordic_cell #(.STAGE(i)) u_pitch (
      .clk(clk), .adv(adv), .c_in(pitch_c[i]), .c_r(pitch_c[i+1])
    );
    qte_cordic_cell #(.STAGE(i)) u_yaw (
      .clk(clk), .adv(adv), .c_in(yaw_c[i]), .c_r(yaw_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        lock_r[i+1] <= lock_r[i];
        neg_r[i+1]  <= neg_r[i];
      end
    end
  end

  // round half up to Q3.13 and clamp
  function automatic logic signed [ZW-1:0] to_q13(input qte_pkg::cordic_t c,
                                                  input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    begin
      r = (c.z + ZW'(32768)) >>> 16;
      if (c.zero) r = '0;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    end
  endfunction

  always_comb begin
    logic signed [ZW-1:0] p;
    p = -to_q13(pitch_c[CORDIC_STEPS], qte_pkg::HALF_PI_Q);
    roll_nxt = 16'(to_q13(roll_c[CORDIC_STEPS], qte_pkg::PI_Q));
    yaw_nxt = 16'(to_q13(yaw_c[CORDIC_STEPS], qte_pkg::PI_Q));
    pitch_nxt = 15'(p);
    // locked: pitch is +pi/2 for negative r20, else -pi/2
    if (lock_r[CORDIC_STEPS]) begin
      yaw_nxt = '0;
      pitch_nxt = neg_r[CORDIC_STEPS] ? 15'(qte_pkg::HALF_PI_Q)
                                      : 15'(-qte_pkg::HALF_PI_Q);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_roll_angle <= roll_nxt;
      out_pitch_angle <= pitch_nxt;
      out_yaw_angle <= yaw_nxt;
      out_gimbal_locked <= lock_r[CORDIC_STEPS];
    end
  end

  a_lock_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gimbal_locked |->
      out_yaw_angle == 16'sd0 &&
      (out_pitch_angle == 15'sd12868 || out_pitch_angle == -15'sd12868))
    else $error("locked result with bad yaw or pitch");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736)
    else $error("roll out of range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted request lost at pipeline entry");

endmodule
`default_nettype wire
